// ----- hdl/lrupr_pkg.sv -----
package lrupr_pkg;

    // Built table size and page tag width (defaults for the top level)
    localparam int FRAMES_DEF     = 8;
    localparam int PAGE_WIDTH_DEF = 16;

    // Fixed port widths
    localparam int PAGE_W  = 16;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Controller -> datapath
    typedef struct packed {
        logic load_in;   // capture the page reference
        logic lookup;    // register match / victim / free search
        logic commit;    // write frame state and load the result register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;  // result register empty or being taken this cycle
    } t_status;

endpackage

// ----- hdl/lrupr_ctrl.sv -----
module lrupr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lrupr_pkg::t_status i_status,
    output lrupr_pkg::t_cmd    o_cmd
);
    import lrupr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   accept;

    assign accept = (r_state == ST_IDLE) && i_in_valid && !r_in_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_stall <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != ST_IDLE);
        end
    end

    assign o_in_stall     = r_in_stall;
    assign o_cmd.load_in  = accept;
    assign o_cmd.lookup   = (r_state == ST_LOOK);
    assign o_cmd.commit   = (r_state == ST_UPD) && i_status.out_free;

    a_accept_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> (r_state == ST_IDLE))
        else $error("item accepted outside idle");

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_LOOK))
        else $error("accepted item did not enter lookup");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_status.out_free)
        else $error("commit while result register blocked");

endmodule

// ----- hdl/lrupr_dp.sv -----
module lrupr_dp #(
    parameter int FRAMES     = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_WIDTH = lrupr_pkg::PAGE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrupr_pkg::t_cmd               i_cmd,
    output lrupr_pkg::t_status            o_status,
    input  logic                          i_cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic [lrupr_pkg::PAGE_W-1:0]  i_page_number,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_hit,
    output logic                          o_evicted_valid,
    output logic [lrupr_pkg::PAGE_W-1:0]  o_evicted_page,
    output logic [lrupr_pkg::COUNT_W-1:0] o_fault_count
);
    import lrupr_pkg::*;

    localparam int AGE_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int USED_W = $clog2(FRAMES + 1);
    localparam int CMP_W  = (USED_W > CFG_W) ? USED_W : CFG_W;

    // frame row
    logic [PAGE_WIDTH-1:0] r_tag [FRAMES];
    logic [FRAMES-1:0]     r_valid;
    logic [AGE_W-1:0]      r_age [FRAMES];
    logic [USED_W-1:0]     r_used;
    logic [COUNT_W-1:0]    r_fault;
    logic [CFG_W-1:0]      r_frame_count;

    // reference and lookup results
    logic [PAGE_WIDTH-1:0] r_page;
    logic [FRAMES-1:0]     r_sel;
    logic                  r_hit;
    logic                  r_full;
    logic [AGE_W-1:0]      r_hit_age;
    logic [PAGE_WIDTH-1:0] r_ev_tag;

    // result register
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic                  r_out_ev_valid;
    logic [PAGE_W-1:0]     r_out_ev_page;

    // lookup logic
    logic [FRAMES-1:0]     match;
    logic [FRAMES-1:0]     oldest;
    logic [FRAMES-1:0]     free_vec;
    logic [AGE_W-1:0]      last_age;
    logic [AGE_W-1:0]      hit_age;
    logic [PAGE_WIDTH-1:0] ev_tag;
    logic [CMP_W-1:0]      cfg_ext;
    logic [CMP_W-1:0]      eff;
    logic                  full;
    logic                  any_hit;
    logic [FRAMES-1:0]     sel;

    // next state
    logic [AGE_W-1:0]      n_age [FRAMES];
    logic [FRAMES-1:0]     n_valid;
    logic [USED_W-1:0]     n_used;
    logic [COUNT_W-1:0]    n_fault;
    logic                  n_out_valid;
    logic                  miss_evict;

    // ages of occupied frames are always 0..used-1, so the LRU frame holds used-1
    assign last_age = AGE_W'(r_used - 1'b1);
    assign free_vec = ~r_valid & (r_valid + 1'b1);   // lowest free frame

    always_comb begin
        hit_age = '0;
        ev_tag  = '0;
        for (int i = 0; i < FRAMES; i++) begin
            match[i]  = r_valid[i] && (r_tag[i] == r_page);
            oldest[i] = r_valid[i] && (r_age[i] == last_age);
            hit_age   = hit_age | (match[i] ? r_age[i] : '0);
            ev_tag    = ev_tag | (oldest[i] ? r_tag[i] : '0);
        end
    end

    always_comb begin
        cfg_ext = CMP_W'(r_frame_count);
        if (r_frame_count == '0) begin
            eff = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(FRAMES)) begin
            eff = CMP_W'(FRAMES);
        end else begin
            eff = cfg_ext;
        end
    end

    assign full    = (CMP_W'(r_used) >= eff);
    assign any_hit = |match;
    assign sel     = any_hit ? match : (full ? oldest : free_vec);

    // commit: selected frame becomes most recent; on a miss all other frames age, on a hit only those more recent
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            n_age[i] = r_age[i];
            if (r_sel[i]) begin
                n_age[i] = '0;
            end else if (r_valid[i] && (!r_hit || (r_age[i] < r_hit_age))) begin
                n_age[i] = r_age[i] + 1'b1;
            end
        end
    end

    assign miss_evict = !r_hit && r_full;
    assign n_valid    = r_hit ? r_valid : (r_valid | r_sel);
    assign n_used     = (!r_hit && !r_full) ? (r_used + 1'b1) : r_used;
    assign n_fault    = (!r_hit && (r_fault != '1)) ? (r_fault + 1'b1) : r_fault;

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign n_out_valid       = i_cmd.commit || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_age         <= '{default: '0};
            r_used        <= '0;
            r_fault       <= '0;
            r_frame_count <= CFG_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_valid <= n_valid;
                r_age   <= n_age;
                r_used  <= n_used;
                r_fault <= n_fault;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_page <= PAGE_WIDTH'(i_page_number);
        end
        if (i_cmd.lookup) begin
            r_sel     <= sel;
            r_hit     <= any_hit;
            r_full    <= full;
            r_hit_age <= hit_age;
            r_ev_tag  <= ev_tag;
        end
        if (i_cmd.commit) begin
            for (int i = 0; i < FRAMES; i++) begin
                if (!r_hit && r_sel[i]) begin
                    r_tag[i] <= r_page;
                end
            end
            r_out_hit      <= r_hit;
            r_out_ev_valid <= miss_evict;
            r_out_ev_page  <= miss_evict ? PAGE_W'(r_ev_tag) : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_count   = r_fault;

    a_used_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == r_used)
        else $error("occupancy count out of step with valid bits");

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> $onehot(r_sel))
        else $error("commit without exactly one target frame");

    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_hit) |=> (r_fault == $past(r_fault)))
        else $error("fault count moved on a hit");

endmodule

// ----- hdl/lru_page_replacement_top.sv -----
// Channel  Valid        Stall         Payload
// -------  -----------  ------------  ---------------------------------------------
// in       i_in_valid   o_in_stall    i_page_number
// out      o_out_valid  i_out_stall   o_hit, o_evicted_valid, o_evicted_page,
//                                     o_fault_count
// cfg      i_cfg_we     (none)        i_cfg_wdata -> frame_count
//
// A new reference is accepted only after the last commits: accept, lookup
//   (registered match / LRU victim / free-frame search over the frame row),
//   commit (frame row update and result register load).
// Commit waits while the result register still holds an untaken item; the
//   input stays stalled from acceptance until that commit.
// Reset is synchronous, active low: clears valid bits, ages, occupancy, fault
//   count and sets frame_count to 8; the input stays stalled in the cycle after.
// Tags are not reset; a frame's tag is only looked at once its valid bit is set.
module lru_page_replacement_top #(
    parameter int FRAMES     = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_WIDTH = lrupr_pkg::PAGE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // frame count register
    input  logic                          i_cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0]   i_cfg_wdata,
    // page references
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lrupr_pkg::PAGE_W-1:0]  i_page_number,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic                          o_evicted_valid,
    output logic [lrupr_pkg::PAGE_W-1:0]  o_evicted_page,
    output logic [lrupr_pkg::COUNT_W-1:0] o_fault_count
);
    import lrupr_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer: idle -> lookup -> update
    lrupr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Frame row, LRU ages, fault counter, result register
    lrupr_dp #(
        .FRAMES     (FRAMES),
        .PAGE_WIDTH (PAGE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_page_number   (i_page_number),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count)
    );

endmodule

// ----- test/lru_frame_checker.sv -----
module lru_frame_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [lrupr_pkg::PAGE_W-1:0]  i_page_number,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_hit,
    input  logic                          i_evicted_valid,
    input  logic [lrupr_pkg::PAGE_W-1:0]  i_evicted_page,
    input  logic [lrupr_pkg::COUNT_W-1:0] i_fault_count,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    import lrupr_pkg::*;

    localparam int NFRAMES = FRAMES_DEF;

    typedef struct packed {
        logic               hit;
        logic               ev_valid;
        logic [PAGE_W-1:0]  ev_page;
        logic [COUNT_W-1:0] faults;
    } t_access_result;

    // shadow frame table
    logic [PAGE_W-1:0]  tag_m   [NFRAMES];
    logic               valid_m [NFRAMES];
    int unsigned        age_m   [NFRAMES];
    logic [COUNT_W-1:0] faults_m;
    logic [CFG_W-1:0]   frame_count_m;

    t_access_result awaited_results[$];
    int mismatches = 0;
    int hits_seen  = 0;
    int in_flight  = 0;

    assign o_errors  = mismatches;
    assign o_hits    = hits_seen;
    assign o_pending = in_flight;

    function automatic void clear_table();
        for (int i = 0; i < NFRAMES; i++) begin
            tag_m[i]   = '0;
            valid_m[i] = 1'b0;
            age_m[i]   = 0;
        end
        faults_m      = '0;
        frame_count_m = CFG_RESET;
    endfunction

    // One page reference against the shadow table; updates it and returns the result.
    function automatic t_access_result reference_page(logic [PAGE_W-1:0] page);
        int             hit_at;
        int             free_at;
        int             victim;
        int             slot;
        int unsigned    used;
        int unsigned    eff;
        int unsigned    limit;
        t_access_result r;
        hit_at  = -1;
        free_at = -1;
        victim  = -1;
        used    = 0;
        r       = '0;
        if (frame_count_m == 0)
            eff = 1;
        else if (frame_count_m > NFRAMES)
            eff = NFRAMES;
        else
            eff = 32'(frame_count_m);
        for (int i = 0; i < NFRAMES; i++) begin
            if (valid_m[i]) begin
                used++;
                if (tag_m[i] == page)
                    hit_at = i;
                if (victim < 0 || age_m[i] > age_m[victim])
                    victim = i;
            end else if (free_at < 0) begin
                free_at = i;
            end
        end
        if (hit_at >= 0) begin
            r.hit = 1'b1;
            slot  = hit_at;
            limit = age_m[hit_at];
        end else begin
            if (faults_m != '1)
                faults_m = faults_m + 1'b1;
            limit = 32'hFFFF_FFFF;
            if (used < eff && free_at >= 0) begin
                slot          = free_at;
                valid_m[slot] = 1'b1;
            end else begin
                slot       = victim;
                r.ev_valid = 1'b1;
                r.ev_page  = tag_m[victim];
            end
            tag_m[slot] = page;
        end
        for (int i = 0; i < NFRAMES; i++) begin
            if (i != slot && valid_m[i] && age_m[i] < limit)
                age_m[i]++;
        end
        age_m[slot] = 0;
        r.faults    = faults_m;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [COUNT_W-1:0] want,
                                          logic [COUNT_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_access_result want;
        int             delta;
        delta = 0;
        if (!i_rst_n) begin
            clear_table();
            awaited_results.delete();
            in_flight <= 0;
        end else begin
            if (i_cfg_we)
                frame_count_m = i_cfg_wdata;
            // results first: the item taken this edge cannot already have one out
            if (i_out_valid && !i_out_stall) begin
                if (i_hit === 1'b1)
                    hits_seen++;
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, %s%0b ev=%0b/%0h faults=%0h",
                             $time, "actual hit=", i_hit, i_evicted_valid,
                             i_evicted_page, i_fault_count);
                end else begin
                    want = awaited_results.pop_front();
                    delta--;
                    compare_field("hit", COUNT_W'(want.hit), COUNT_W'(i_hit));
                    compare_field("evicted_valid", COUNT_W'(want.ev_valid),
                                  COUNT_W'(i_evicted_valid));
                    compare_field("evicted_page", COUNT_W'(want.ev_page),
                                  COUNT_W'(i_evicted_page));
                    compare_field("fault_count", want.faults, i_fault_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_results = {awaited_results, reference_page(i_page_number)};
                delta++;
            end
            in_flight <= in_flight + delta;
        end
    end

endmodule

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lrupr_pkg::*;

    // Results trail acceptance by the lookup and update states; leave margin for draining.
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 125;
    localparam int QUIET_PHASES   = 2;    // last phases run with no idling at all

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata    = '0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [PAGE_W-1:0]  page_number  = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic               hit;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_count;

    int errors;
    int pending;
    int hits;

    // idling knobs, in percent: input gaps per item offered, output stalls per cycle
    int gap_pct    = 0;
    int stall_pct  = 0;
    int stall_left = 0;

    int items_sent = 0;
    int cfg_writes = 0;

    // working set for the random part: mostly re-referenced pages so hits,
    // promotions at every age and evictions of old pages all happen
    logic [PAGE_W-1:0] working_set [16];
    int                set_size;
    logic [PAGE_W-1:0] last_page = '0;

    always #2 clk = ~clk;

    lru_page_replacement_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_page_number   (page_number),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_hit           (hit),
        .o_evicted_valid (evicted_valid),
        .o_evicted_page  (evicted_page),
        .o_fault_count   (fault_count)
    );

    lru_frame_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_page_number   (page_number),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_hit           (hit),
        .i_evicted_valid (evicted_valid),
        .i_evicted_page  (evicted_page),
        .i_fault_count   (fault_count),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_hits          (hits)
    );

    // Result-side backpressure: random stall bursts.
    always @(posedge clk) begin
        if (!rst_n || stall_pct == 0) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 6);
        end
    end

    // Offer one item, optionally after an idle burst, and hold it until taken.
    // Valid stays high on return so back-to-back items need no extra edge.
    task automatic issue_page(input logic [PAGE_W-1:0] pg);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid    <= 1'b0;
            page_number <= PAGE_W'($urandom);    // payload is don't-care while idle
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        page_number <= pg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        last_page = pg;
        items_sent++;
    endtask

    // Sender holds off until every reference has its result, then waits out a
    // settling margin so nothing is left in flight.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the block drained.
    task automatic write_frame_count(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    task automatic pick_working_set();
        logic [PAGE_W-1:0] base;
        base     = PAGE_W'($urandom);
        set_size = $urandom_range(2, 14);
        for (int i = 0; i < 16; i++) begin
            // odd-sized sets are clustered pages, even-sized ones scattered
            if (set_size[0])
                working_set[i] = base + i[PAGE_W-1:0];
            else
                working_set[i] = PAGE_W'($urandom);
        end
    endtask

    function automatic logic [PAGE_W-1:0] next_random_page();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return working_set[$urandom_range(0, set_size - 1)];
        else if (r < 85)
            return last_page;           // immediate re-reference of the newest page
        else
            return PAGE_W'($urandom);   // cold page, nearly always a fault
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0: begin
                return 0;
            end
            1: begin
                return 10;
            end
            2: begin
                return 30;
            end
            default: begin
                return 60;
            end
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        gap_pct   <= 20;
        stall_pct <= 20;

        // Frame count of zero behaves as one frame: every new page evicts the last.
        write_frame_count(4'd0);
        issue_page(16'h0000);           // free frame
        issue_page(16'hFFFF);           // evicts 0000
        issue_page(16'hFFFF);           // hit
        issue_page(16'h0000);           // evicts FFFF

        // Two frames: one more free frame, then LRU eviction between two pages.
        write_frame_count(4'd2);
        issue_page(16'hAAAA);           // second frame
        issue_page(16'h0000);           // hit at age 1, AAAA becomes oldest
        issue_page(16'h5555);           // evicts AAAA

        // Count above the table size is clamped to the full table.
        write_frame_count(4'd15);
        issue_page(16'h0001);
        issue_page(16'h8000);
        issue_page(16'h7FFF);
        issue_page(16'h1234);
        issue_page(16'h4321);
        issue_page(16'h0F0F);           // table now full
        issue_page(16'h0000);           // hit on an old frame
        issue_page(16'h5555);           // hit
        issue_page(16'h9999);           // evicts the least recent page
        issue_page(16'h0001);           // miss (0001 was the page just evicted); evicts 8000

        // Lowering the count while full flushes nothing; misses still evict one.
        write_frame_count(4'd3);
        issue_page(16'h3333);
        issue_page(16'h3333);
        issue_page(16'h0F0F);

        write_frame_count(4'd8);
        issue_page(16'hFFFF);

        // ---------------- random part ----------------
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0)
                write_frame_count(4'd1);
            else if (ph == 1)
                write_frame_count(4'd8);
            else
                write_frame_count(CFG_W'($urandom_range(0, 15)));
            pick_working_set();
            if (ph >= RANDOM_PHASES - QUIET_PHASES) begin
                gap_pct   <= 0;
                stall_pct <= 0;
            end else begin
                gap_pct   <= pick_idle_pct();
                stall_pct <= pick_idle_pct();
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // occasionally switch working set mid-phase to force eviction runs
                if ($urandom_range(0, 99) == 0)
                    pick_working_set();
                issue_page(next_random_page());
            end
        end

        wait_drained();

        $display("Run covered %0d page references (%0d hits) and %0d frame-count writes,",
                 items_sent, hits, cfg_writes);
        $display("with idle and stall bursts on both channels and a final stretch at full rate.");
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still awaited", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
